### rtl/mcts_pkg.sv
// ----------------------------------------------------------------------------
// MACD crossover trade signal package
// Shared widths, constants, codes and the EMA update used by the block.
// ----------------------------------------------------------------------------
package mcts_pkg;

  // Field and state widths
  localparam int PriceW        = 32;
  localparam int StampW        = 32;
  localparam int CapW          = 48;
  localparam int HalfW         = CapW / 2;
  localparam int EmaW          = 40;
  localparam int SumW          = 48;
  localparam int CntW          = 10;
  localparam int PerW          = 8;
  localparam int WgtW          = 16;
  localparam int DdW           = 23;
  localparam int TallyW        = 16;
  localparam int PriceFracBits = 16;
  localparam int CoinShift     = 16 + PriceFracBits;
  localparam int ProdW         = HalfW + PriceW;
  localparam int DivNumW       = CapW + CoinShift;
  localparam int DivSteps      = DivNumW;
  localparam int DivCntW       = $clog2(DivSteps);
  localparam int CfgIdxW       = 3;
  localparam int InDataW       = PriceW + StampW;
  localparam int OutBits       = StampW + CapW + 3 + DdW + 2 * TallyW + CapW;
  localparam int OutDataW      = ((OutBits + 7) / 8) * 8;

  localparam logic [CntW-1:0]    CountMax = '1;
  localparam logic [TallyW-1:0]  TallyMax = '1;
  localparam logic [PriceW-1:0]  DdScale  = PriceW'(100 * 65536);

  // Register reset values
  localparam logic [PerW-1:0] FastPeriodRst   = 8'd12;
  localparam logic [PerW-1:0] SlowPeriodRst   = 8'd26;
  localparam logic [PerW-1:0] SignalPeriodRst = 8'd9;
  localparam logic [WgtW-1:0] FastWeightRst   = 16'd10082;
  localparam logic [WgtW-1:0] SlowWeightRst   = 16'd4855;
  localparam logic [WgtW-1:0] SignalWeightRst = 16'd13107;
  localparam logic [CapW-1:0] StartCapRst     = 48'd65536000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAST_PERIOD   = 3'd0,
    CFG_SLOW_PERIOD   = 3'd1,
    CFG_SIGNAL_PERIOD = 3'd2,
    CFG_FAST_WEIGHT   = 3'd3,
    CFG_SLOW_WEIGHT   = 3'd4,
    CFG_SIGNAL_WEIGHT = 3'd5,
    CFG_START_CAPITAL = 3'd6
  } cfg_idx_e;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE      = 5'd0,
    OP_LOAD      = 5'd1,
    OP_FAST      = 5'd2,
    OP_SLOW      = 5'd3,
    OP_SIG       = 5'd4,
    OP_TRADE     = 5'd5,
    OP_MUL_HI    = 5'd6,
    OP_MUL_LO    = 5'd7,
    OP_EQUITY    = 5'd8,
    OP_DD_HI     = 5'd9,
    OP_DD_LO     = 5'd10,
    OP_DD_DIV    = 5'd11,
    OP_SEED_FAST = 5'd12,
    OP_SEED_SLOW = 5'd13,
    OP_SEED_SIG  = 5'd14,
    OP_COINS     = 5'd15,
    OP_DD_WRITE  = 5'd16,
    OP_FINISH    = 5'd17
  } op_e;

  // Controller states, one-hot
  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_FAST  = 17'h00002,
    ST_FWAIT = 17'h00004,
    ST_SLOW  = 17'h00008,
    ST_SWAIT = 17'h00010,
    ST_SIG   = 17'h00020,
    ST_GWAIT = 17'h00040,
    ST_TRADE = 17'h00080,
    ST_BWAIT = 17'h00100,
    ST_MULH  = 17'h00200,
    ST_MULL  = 17'h00400,
    ST_EQU   = 17'h00800,
    ST_DDH   = 17'h01000,
    ST_DDL   = 17'h02000,
    ST_DDIV  = 17'h04000,
    ST_DWAIT = 17'h08000,
    ST_FIN   = 17'h10000
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic fast_seed;
    logic slow_seed;
    logic sig_seed;
    logic buy;
    logic div_done;
    logic peak_zero;
    logic out_free;
  } status_t;

  // One EMA update: ema + floor((x - ema) * w / 2^16)
  function automatic logic signed [EmaW-1:0] ema_step(input logic signed [EmaW-1:0] ema,
                                                      input logic signed [EmaW-1:0] x,
                                                      input logic [WgtW-1:0] w);
    logic signed [EmaW:0]          diff;
    logic signed [EmaW+WgtW+1:0]   prod;
    diff = $signed({x[EmaW-1], x}) - $signed({ema[EmaW-1], ema});
    prod = diff * $signed({1'b0, w});
    return ema + $signed(prod[EmaW+WgtW-1:WgtW]);
  endfunction

endpackage

### rtl/mcts_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle, quotient saturated to 48 bits.
// ----------------------------------------------------------------------------
module mcts_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [mcts_pkg::DivNumW-1:0]     num_i,
  input  logic [mcts_pkg::CapW-1:0]        den_i,
  output logic [mcts_pkg::CapW-1:0]        quot_o,
  output logic                             done_o
);

  logic [mcts_pkg::DivNumW-1:0] num_q, num_d;
  logic [mcts_pkg::CapW-1:0]    den_q, den_d;
  logic [mcts_pkg::CapW-1:0]    rem_q, rem_d;
  logic [mcts_pkg::CapW-1:0]    quo_q, quo_d;
  logic                         sat_q, sat_d;
  logic [mcts_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [mcts_pkg::CapW:0]      rem_sh;
  logic                         ge;

  // One shift-and-subtract step per cycle
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, num_q[mcts_pkg::DivNumW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      sat_d  = 1'b0;
      cnt_d  = mcts_pkg::DivCntW'(mcts_pkg::DivSteps - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[mcts_pkg::DivNumW-2:0], 1'b0};
      rem_d = ge ? mcts_pkg::CapW'(rem_sh - {1'b0, den_q}) : rem_sh[mcts_pkg::CapW-1:0];
      quo_d = {quo_q[mcts_pkg::CapW-2:0], ge};
      sat_d = sat_q | quo_q[mcts_pkg::CapW-1];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign quot_o = sat_q ? '1 : quo_q;
  assign done_o = done_q;

endmodule

### rtl/mcts_dp.sv
// ----------------------------------------------------------------------------
// MACD crossover datapath
// Configuration, EMA and trading state, shared multiplier, divider, output stage.
// ----------------------------------------------------------------------------
module mcts_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcts_pkg::cmd_t                    cmd_i,
  output mcts_pkg::status_t                 status_o,
  input  logic [mcts_pkg::PriceW-1:0]       price_i,
  input  logic [mcts_pkg::StampW-1:0]       stamp_i,
  input  logic                              last_i,
  input  logic                              cfg_we_i,
  input  logic [mcts_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mcts_pkg::CapW-1:0]         cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mcts_pkg::OutDataW-1:0]     out_data_o,
  output logic                              out_last_o
);

  // Configuration registers
  logic [mcts_pkg::PerW-1:0] fast_period_q, slow_period_q, signal_period_q;
  logic [mcts_pkg::WgtW-1:0] fast_weight_q, slow_weight_q, signal_weight_q;
  logic [mcts_pkg::CapW-1:0] start_capital_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_period_q   <= mcts_pkg::FastPeriodRst;
      slow_period_q   <= mcts_pkg::SlowPeriodRst;
      signal_period_q <= mcts_pkg::SignalPeriodRst;
      fast_weight_q   <= mcts_pkg::FastWeightRst;
      slow_weight_q   <= mcts_pkg::SlowWeightRst;
      signal_weight_q <= mcts_pkg::SignalWeightRst;
      start_capital_q <= mcts_pkg::StartCapRst;
    end else if (cfg_we_i) begin
      unique case (mcts_pkg::cfg_idx_e'(cfg_idx_i))
        mcts_pkg::CFG_FAST_PERIOD:   fast_period_q   <= cfg_data_i[mcts_pkg::PerW-1:0];
        mcts_pkg::CFG_SLOW_PERIOD:   slow_period_q   <= cfg_data_i[mcts_pkg::PerW-1:0];
        mcts_pkg::CFG_SIGNAL_PERIOD: signal_period_q <= cfg_data_i[mcts_pkg::PerW-1:0];
        mcts_pkg::CFG_FAST_WEIGHT:   fast_weight_q   <= cfg_data_i[mcts_pkg::WgtW-1:0];
        mcts_pkg::CFG_SLOW_WEIGHT:   slow_weight_q   <= cfg_data_i[mcts_pkg::WgtW-1:0];
        mcts_pkg::CFG_SIGNAL_WEIGHT: signal_weight_q <= cfg_data_i[mcts_pkg::WgtW-1:0];
        mcts_pkg::CFG_START_CAPITAL: start_capital_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State
  logic [mcts_pkg::PriceW-1:0]      price_q, price_d;
  logic [mcts_pkg::StampW-1:0]      stamp_q, stamp_d;
  logic                             last_q, last_d;
  logic [mcts_pkg::CntW-1:0]        count_q, count_d;
  logic [mcts_pkg::SumW-1:0]        fast_sum_q, fast_sum_d, slow_sum_q, slow_sum_d;
  logic signed [mcts_pkg::SumW-1:0] sig_sum_q, sig_sum_d;
  logic signed [mcts_pkg::EmaW-1:0] fast_avg_q, fast_avg_d, slow_avg_q, slow_avg_d;
  logic signed [mcts_pkg::EmaW-1:0] sig_avg_q, sig_avg_d, macd_q, macd_d;
  logic signed [mcts_pkg::EmaW-1:0] macd_before_q, macd_before_d;
  logic signed [mcts_pkg::EmaW-1:0] sig_before_q, sig_before_d;
  logic                             open_q, open_d, buy_q, buy_d, sell_q, sell_d;
  logic [mcts_pkg::CapW-1:0]        cash_q, cash_d, coins_q, coins_d;
  logic [mcts_pkg::CapW-1:0]        peak_q, peak_d, equity_q, equity_d;
  logic [mcts_pkg::PriceW-1:0]      entry_q, entry_d;
  logic [mcts_pkg::DdW-1:0]         dd_max_q, dd_max_d;
  logic [mcts_pkg::TallyW-1:0]      trades_q, trades_d, wins_q, wins_d;
  logic [mcts_pkg::ProdW-1:0]       prod_hi_q, prod_hi_d, prod_lo_q, prod_lo_d;

  // Clamped periods and phase decode
  logic [mcts_pkg::PerW-1:0] s_per, f_per, g_per;
  logic [mcts_pkg::CntW-1:0] base, trade_start, count_inc;
  logic                      fast_warm, slow_warm, sig_on, sig_warm, trade_on;
  logic                      fast_seed, slow_seed, sig_seed, buy_now, sell_now;

  always_comb begin
    s_per = (slow_period_q < 8'd2) ? 8'd2 : slow_period_q;
    f_per = (fast_period_q >= s_per) ? s_per - 8'd1 : fast_period_q;
    if (f_per == '0) f_per = 8'd1;
    g_per = (signal_period_q == '0) ? 8'd1 : signal_period_q;
  end

  assign base        = mcts_pkg::CntW'(s_per) - 10'd1;
  assign trade_start = base + mcts_pkg::CntW'(g_per);
  assign count_inc   = count_q + 10'd1;
  assign fast_warm   = count_q < mcts_pkg::CntW'(f_per);
  assign slow_warm   = count_q < mcts_pkg::CntW'(s_per);
  assign sig_on      = count_q >= base;
  assign sig_warm    = sig_on && (count_q < trade_start);
  assign trade_on    = count_q >= trade_start;
  assign fast_seed   = fast_warm && (count_inc == mcts_pkg::CntW'(f_per));
  assign slow_seed   = slow_warm && (count_inc == mcts_pkg::CntW'(s_per));
  assign sig_seed    = sig_warm && (count_inc == trade_start);
  assign buy_now     = trade_on && !open_q && (macd_before_q <= sig_before_q)
                       && (macd_q > sig_avg_q);
  assign sell_now    = trade_on && open_q && (macd_before_q >= sig_before_q)
                       && (macd_q < sig_avg_q);

  // MACD and signal seed numerator
  logic signed [mcts_pkg::EmaW-1:0] macd_now;
  logic signed [mcts_pkg::SumW-1:0] sig_sum_new;
  logic [mcts_pkg::SumW:0]          sig_mag;

  assign macd_now    = fast_avg_q - slow_avg_q;
  assign sig_sum_new = sig_sum_q + mcts_pkg::SumW'(macd_now);
  assign sig_mag     = sig_sum_new[mcts_pkg::SumW-1]
                       ? (49'd0 - {sig_sum_new[mcts_pkg::SumW-1], sig_sum_new})
                         + {41'd0, g_per} - 49'd1
                       : {1'b0, sig_sum_new};

  // Shared 24 x 32 multiplier
  logic [mcts_pkg::HalfW-1:0]  mul_a;
  logic [mcts_pkg::PriceW-1:0] mul_b;
  logic [mcts_pkg::ProdW-1:0]  mul_p;
  logic [mcts_pkg::CapW-1:0]   dd_diff;
  logic [mcts_pkg::DivNumW-1:0] prod_sum;
  logic [mcts_pkg::CapW-1:0]   held_value;

  assign dd_diff = peak_q - equity_q;

  always_comb begin
    case (cmd_i.op)
      mcts_pkg::OP_MUL_HI: mul_a = coins_q[mcts_pkg::CapW-1:mcts_pkg::HalfW];
      mcts_pkg::OP_MUL_LO: mul_a = coins_q[mcts_pkg::HalfW-1:0];
      mcts_pkg::OP_DD_HI:  mul_a = dd_diff[mcts_pkg::CapW-1:mcts_pkg::HalfW];
      default:             mul_a = dd_diff[mcts_pkg::HalfW-1:0];
    endcase
    mul_b = (cmd_i.op == mcts_pkg::OP_MUL_HI || cmd_i.op == mcts_pkg::OP_MUL_LO)
            ? price_q : mcts_pkg::DdScale;
  end

  assign mul_p      = mcts_pkg::ProdW'(mul_a) * mcts_pkg::ProdW'(mul_b);
  assign prod_sum   = {prod_hi_q, {mcts_pkg::HalfW{1'b0}}}
                      + {{mcts_pkg::HalfW{1'b0}}, prod_lo_q};
  assign held_value = prod_sum[mcts_pkg::CoinShift +: mcts_pkg::CapW];

  // Divider operand selection
  logic                          div_start, div_done;
  logic [mcts_pkg::DivNumW-1:0]  div_num;
  logic [mcts_pkg::CapW-1:0]     div_den, quot;

  always_comb begin
    div_start = 1'b0;
    div_num   = prod_sum;
    div_den   = peak_q;
    case (cmd_i.op)
      mcts_pkg::OP_FAST: begin
        div_start = fast_seed;
        div_num   = mcts_pkg::DivNumW'(fast_sum_q + mcts_pkg::SumW'(price_q));
        div_den   = mcts_pkg::CapW'(f_per);
      end
      mcts_pkg::OP_SLOW: begin
        div_start = slow_seed;
        div_num   = mcts_pkg::DivNumW'(slow_sum_q + mcts_pkg::SumW'(price_q));
        div_den   = mcts_pkg::CapW'(s_per);
      end
      mcts_pkg::OP_SIG: begin
        div_start = sig_seed;
        div_num   = mcts_pkg::DivNumW'(sig_mag);
        div_den   = mcts_pkg::CapW'(g_per);
      end
      mcts_pkg::OP_TRADE: begin
        div_start = buy_now;
        div_num   = {cash_q, {mcts_pkg::CoinShift{1'b0}}};
        div_den   = mcts_pkg::CapW'(price_q);
      end
      mcts_pkg::OP_DD_DIV: begin
        div_start = (peak_q != '0);
      end
      default: ;
    endcase
  end

  mcts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  // Output stage
  logic                              out_valid_q, out_valid_d, out_free;
  logic [mcts_pkg::OutDataW-1:0]     out_data_q, out_data_d;
  logic                              out_last_q, out_last_d;
  logic signed [mcts_pkg::CapW:0]    net_wide;
  logic [mcts_pkg::CapW-1:0]         net_sat, net_out;

  assign out_free = !out_valid_q || out_ready_i;
  assign net_wide = $signed({1'b0, equity_q}) - $signed({1'b0, start_capital_q});

  always_comb begin
    if (!net_wide[mcts_pkg::CapW] && net_wide[mcts_pkg::CapW-1]) begin
      net_sat = {1'b0, {(mcts_pkg::CapW-1){1'b1}}};
    end else if (net_wide[mcts_pkg::CapW] && !net_wide[mcts_pkg::CapW-1]) begin
      net_sat = {1'b1, {(mcts_pkg::CapW-1){1'b0}}};
    end else begin
      net_sat = net_wide[mcts_pkg::CapW-1:0];
    end
    net_out = last_q ? net_sat : '0;
  end

  // Operation decoder
  always_comb begin
    price_d       = price_q;
    stamp_d       = stamp_q;
    last_d        = last_q;
    count_d       = count_q;
    fast_sum_d    = fast_sum_q;
    slow_sum_d    = slow_sum_q;
    sig_sum_d     = sig_sum_q;
    fast_avg_d    = fast_avg_q;
    slow_avg_d    = slow_avg_q;
    sig_avg_d     = sig_avg_q;
    macd_d        = macd_q;
    macd_before_d = macd_before_q;
    sig_before_d  = sig_before_q;
    open_d        = open_q;
    buy_d         = buy_q;
    sell_d        = sell_q;
    cash_d        = cash_q;
    coins_d       = coins_q;
    peak_d        = peak_q;
    equity_d      = equity_q;
    entry_d       = entry_q;
    dd_max_d      = dd_max_q;
    trades_d      = trades_q;
    wins_d        = wins_q;
    prod_hi_d     = prod_hi_q;
    prod_lo_d     = prod_lo_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;
    unique case (cmd_i.op)
      mcts_pkg::OP_LOAD: begin
        price_d = price_i;
        stamp_d = stamp_i;
        last_d  = last_i;
        if (count_q == '0) begin
          cash_d = start_capital_q;
          peak_d = start_capital_q;
        end
      end
      mcts_pkg::OP_FAST: begin
        if (fast_warm) fast_sum_d = fast_sum_q + mcts_pkg::SumW'(price_q);
        else fast_avg_d = mcts_pkg::ema_step(fast_avg_q, $signed({8'd0, price_q}),
                                             fast_weight_q);
      end
      mcts_pkg::OP_SLOW: begin
        if (slow_warm) slow_sum_d = slow_sum_q + mcts_pkg::SumW'(price_q);
        else slow_avg_d = mcts_pkg::ema_step(slow_avg_q, $signed({8'd0, price_q}),
                                             slow_weight_q);
      end
      mcts_pkg::OP_SIG: begin
        macd_d = sig_on ? macd_now : '0;
        if (sig_warm) sig_sum_d = sig_sum_new;
        else if (sig_on) sig_avg_d = mcts_pkg::ema_step(sig_avg_q, macd_now, signal_weight_q);
      end
      mcts_pkg::OP_SEED_FAST: fast_avg_d = $signed(quot[mcts_pkg::EmaW-1:0]);
      mcts_pkg::OP_SEED_SLOW: slow_avg_d = $signed(quot[mcts_pkg::EmaW-1:0]);
      mcts_pkg::OP_SEED_SIG: begin
        sig_avg_d = sig_sum_q[mcts_pkg::SumW-1] ? -$signed(quot[mcts_pkg::EmaW-1:0])
                                                : $signed(quot[mcts_pkg::EmaW-1:0]);
      end
      mcts_pkg::OP_TRADE: begin
        buy_d         = buy_now;
        sell_d        = sell_now;
        macd_before_d = macd_q;
        sig_before_d  = sig_avg_q;
        if (count_q != mcts_pkg::CountMax) count_d = count_inc;
        if (buy_now) begin
          cash_d  = '0;
          entry_d = price_q;
          open_d  = 1'b1;
        end
      end
      mcts_pkg::OP_COINS: coins_d = quot;
      mcts_pkg::OP_MUL_HI, mcts_pkg::OP_DD_HI: prod_hi_d = mul_p;
      mcts_pkg::OP_MUL_LO, mcts_pkg::OP_DD_LO: prod_lo_d = mul_p;
      mcts_pkg::OP_EQUITY: begin
        equity_d = open_q ? held_value : cash_q;
        if ((open_q ? held_value : cash_q) > peak_q) peak_d = open_q ? held_value : cash_q;
        // A sell settles the position into cash at the current price.
        if (sell_q) begin
          cash_d  = held_value;
          coins_d = '0;
          open_d  = 1'b0;
          if (trades_q != mcts_pkg::TallyMax) trades_d = trades_q + 1'b1;
          if (price_q > entry_q && wins_q != mcts_pkg::TallyMax) wins_d = wins_q + 1'b1;
        end
      end
      mcts_pkg::OP_DD_WRITE: begin
        if (quot[mcts_pkg::DdW-1:0] > dd_max_q) dd_max_d = quot[mcts_pkg::DdW-1:0];
      end
      mcts_pkg::OP_FINISH: begin
        out_valid_d = 1'b1;
        out_last_d  = last_q;
        out_data_d  = mcts_pkg::OutDataW'({net_out, wins_q, trades_q, dd_max_q, open_q,
                                           sell_q, buy_q, equity_q, stamp_q});
        // End of series: state returns to its reset values.
        if (last_q) begin
          count_d       = '0;
          fast_sum_d    = '0;
          slow_sum_d    = '0;
          sig_sum_d     = '0;
          fast_avg_d    = '0;
          slow_avg_d    = '0;
          sig_avg_d     = '0;
          macd_before_d = '0;
          sig_before_d  = '0;
          open_d        = 1'b0;
          cash_d        = start_capital_q;
          coins_d       = '0;
          entry_d       = '0;
          peak_d        = start_capital_q;
          dd_max_d      = '0;
          trades_d      = '0;
          wins_d        = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      fast_sum_q    <= '0;
      slow_sum_q    <= '0;
      sig_sum_q     <= '0;
      fast_avg_q    <= '0;
      slow_avg_q    <= '0;
      sig_avg_q     <= '0;
      macd_before_q <= '0;
      sig_before_q  <= '0;
      open_q        <= 1'b0;
      buy_q         <= 1'b0;
      sell_q        <= 1'b0;
      cash_q        <= mcts_pkg::StartCapRst;
      coins_q       <= '0;
      peak_q        <= mcts_pkg::StartCapRst;
      entry_q       <= '0;
      dd_max_q      <= '0;
      trades_q      <= '0;
      wins_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      count_q       <= count_d;
      fast_sum_q    <= fast_sum_d;
      slow_sum_q    <= slow_sum_d;
      sig_sum_q     <= sig_sum_d;
      fast_avg_q    <= fast_avg_d;
      slow_avg_q    <= slow_avg_d;
      sig_avg_q     <= sig_avg_d;
      macd_before_q <= macd_before_d;
      sig_before_q  <= sig_before_d;
      open_q        <= open_d;
      buy_q         <= buy_d;
      sell_q        <= sell_d;
      cash_q        <= cash_d;
      coins_q       <= coins_d;
      peak_q        <= peak_d;
      entry_q       <= entry_d;
      dd_max_q      <= dd_max_d;
      trades_q      <= trades_d;
      wins_q        <= wins_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    price_q    <= price_d;
    stamp_q    <= stamp_d;
    last_q     <= last_d;
    macd_q     <= macd_d;
    equity_q   <= equity_d;
    prod_hi_q  <= prod_hi_d;
    prod_lo_q  <= prod_lo_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign status_o.fast_seed = fast_seed;
  assign status_o.slow_seed = slow_seed;
  assign status_o.sig_seed  = sig_seed;
  assign status_o.buy       = buy_now;
  assign status_o.div_done  = div_done;
  assign status_o.peak_zero = (peak_q == '0);
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

### rtl/mcts_ctrl.sv
// ----------------------------------------------------------------------------
// MACD crossover controller
// Sequences the datapath steps for one price sample at a time.
// ----------------------------------------------------------------------------
module mcts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mcts_pkg::status_t  status_i,
  output mcts_pkg::cmd_t     cmd_o
);

  mcts_pkg::state_e state_q, state_d;

  // Next state and command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = mcts_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      mcts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = mcts_pkg::OP_LOAD;
          state_d  = mcts_pkg::ST_FAST;
        end
      end
      mcts_pkg::ST_FAST: begin
        cmd_o.op = mcts_pkg::OP_FAST;
        state_d  = status_i.fast_seed ? mcts_pkg::ST_FWAIT : mcts_pkg::ST_SLOW;
      end
      mcts_pkg::ST_FWAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = mcts_pkg::OP_SEED_FAST;
          state_d  = mcts_pkg::ST_SLOW;
        end
      end
      mcts_pkg::ST_SLOW: begin
        cmd_o.op = mcts_pkg::OP_SLOW;
        state_d  = status_i.slow_seed ? mcts_pkg::ST_SWAIT : mcts_pkg::ST_SIG;
      end
      mcts_pkg::ST_SWAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = mcts_pkg::OP_SEED_SLOW;
          state_d  = mcts_pkg::ST_SIG;
        end
      end
      mcts_pkg::ST_SIG: begin
        cmd_o.op = mcts_pkg::OP_SIG;
        state_d  = status_i.sig_seed ? mcts_pkg::ST_GWAIT : mcts_pkg::ST_TRADE;
      end
      mcts_pkg::ST_GWAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = mcts_pkg::OP_SEED_SIG;
          state_d  = mcts_pkg::ST_TRADE;
        end
      end
      mcts_pkg::ST_TRADE: begin
        cmd_o.op = mcts_pkg::OP_TRADE;
        state_d  = status_i.buy ? mcts_pkg::ST_BWAIT : mcts_pkg::ST_MULH;
      end
      mcts_pkg::ST_BWAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = mcts_pkg::OP_COINS;
          state_d  = mcts_pkg::ST_MULH;
        end
      end
      mcts_pkg::ST_MULH: begin
        cmd_o.op = mcts_pkg::OP_MUL_HI;
        state_d  = mcts_pkg::ST_MULL;
      end
      mcts_pkg::ST_MULL: begin
        cmd_o.op = mcts_pkg::OP_MUL_LO;
        state_d  = mcts_pkg::ST_EQU;
      end
      mcts_pkg::ST_EQU: begin
        cmd_o.op = mcts_pkg::OP_EQUITY;
        state_d  = mcts_pkg::ST_DDH;
      end
      mcts_pkg::ST_DDH: begin
        cmd_o.op = mcts_pkg::OP_DD_HI;
        state_d  = mcts_pkg::ST_DDL;
      end
      mcts_pkg::ST_DDL: begin
        cmd_o.op = mcts_pkg::OP_DD_LO;
        state_d  = mcts_pkg::ST_DDIV;
      end
      mcts_pkg::ST_DDIV: begin
        // A zero peak means zero drawdown, so the division is skipped.
        cmd_o.op = mcts_pkg::OP_DD_DIV;
        state_d  = status_i.peak_zero ? mcts_pkg::ST_FIN : mcts_pkg::ST_DWAIT;
      end
      mcts_pkg::ST_DWAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = mcts_pkg::OP_DD_WRITE;
          state_d  = mcts_pkg::ST_FIN;
        end
      end
      mcts_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = mcts_pkg::OP_FINISH;
          state_d  = mcts_pkg::ST_IDLE;
        end
      end
      default: state_d = mcts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/macd_crossover_trade_signal_unit.sv
// ----------------------------------------------------------------------------
// MACD crossover trade signal unit
// Price samples in, per-sample portfolio results out.
// ----------------------------------------------------------------------------
// Each input transaction on the s_axis side carries one price sample and its
// timestamp; tlast marks the last sample of a series. Each sample yields exactly
// one result transaction on the m_axis side, tlast set on the last one, after
// which all series state returns to its reset values.
// Each EMA seed and each buy runs a division on the shared restoring divider,
// which produces one quotient bit per cycle over 80 steps; the drawdown
// division runs on every sample whose peak is nonzero. The block works on one
// sample at a time.
// A finished result waits in the output register; while it waits, the next
// sample is accepted and processed, and the block only holds at its final step
// if the previous result has still not been taken.
// Reset restores the register defaults and clears the series state. The user must
// write registers through the cfg port while no sample is in flight; not enforced.
// ----------------------------------------------------------------------------
module macd_crossover_trade_signal_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // price [31:0], stamp [63:32]
  input  logic [mcts_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // stamp_out [31:0], equity [79:32], buy_flag [80], sell_flag [81], holding [82],
  // worst_drawdown [105:83], trades_done [121:106], trades_won [137:122],
  // net_profit [185:138], zero fill [191:186]
  output logic [mcts_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [mcts_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mcts_pkg::CapW-1:0]         cfg_data_i
);

  mcts_pkg::cmd_t    cmd;
  mcts_pkg::status_t status;

  mcts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .price_i     (s_axis_tdata[mcts_pkg::PriceW-1:0]),
    .stamp_i     (s_axis_tdata[mcts_pkg::InDataW-1:mcts_pkg::PriceW]),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### rtl/mcts_checker.sv
// ----------------------------------------------------------------------------
// MACD crossover port checker
// Checks on the result stream as seen at the top-level ports.
// ----------------------------------------------------------------------------
module mcts_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [mcts_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           m_axis_tlast
);

  // A stalled result stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Buy and sell never happen on the same sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[80] && m_axis_tdata[81]))
    else $error("buy and sell on one sample");

  // A buy leaves a position open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[80] |-> m_axis_tdata[82])
    else $error("buy without open position");

  // A sell closes the position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[81] |-> !m_axis_tdata[82])
    else $error("sell with position still open");

  // Net profit is reported only on the last result of a series.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[185:138] == '0)
    else $error("net profit outside series end");

endmodule

bind macd_crossover_trade_signal_unit mcts_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
